### hdl/cfb_pkg.sv
// types, constants and codes shared by the checksummed frame builder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cfb_pkg;

   localparam int unsigned MAX_WORDS   = 507;
   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic [16:0] MAX_WORDS_LIMIT = 17'(MAX_WORDS);

   localparam logic [7:0]  HEAD_HI   = 8'h5a;
   localparam logic [7:0]  HEAD_LO   = 8'ha5;
   localparam logic [15:0] HEAD_WORD = {HEAD_HI, HEAD_LO};

   localparam logic OP_START = 1'b0;
   localparam logic OP_DATA  = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [15:0] command;
      logic [8:0]  word_count;
      logic [15:0] address;
      logic [15:0] data_word;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
      logic       error;
   } rsp_type;

   typedef enum logic [1:0] {
      JOB_ERROR  = 2'd0,
      JOB_HEADER = 2'd1,
      JOB_DATA   = 2'd2
   } job_kind_type;

   // one classified transaction handed from the front to the back
   typedef struct packed {
      job_kind_type kind;
      logic [15:0]  word;
      logic [8:0]   count;
      logic [15:0]  address;
      logic [15:0]  checksum;
      logic         close;
   } job_type;

   localparam int unsigned BYTE_IDX_W = 4;

endpackage

`default_nettype wire

### hdl/cfb_front.sv
// front end: classifies request transactions and keeps the frame state
// depends on cfb_pkg
`timescale 1ns / 1ps
`default_nettype none

module cfb_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            accept,
   input  wire cfb_pkg::req_type req,
   output cfb_pkg::job_type     job
);

   logic        frame_open_ff, frame_open_in;
   logic [8:0]  remaining_ff, remaining_in;
   logic [15:0] sum_ff, sum_in;

   logic [15:0] seed;
   logic [15:0] data_sum;
   logic [8:0]  remaining_dec;
   logic        too_large;

   assign seed          = 16'(cfb_pkg::HEAD_WORD + req.command + 16'(req.word_count)
                              + req.address);
   assign data_sum      = sum_ff + req.data_word;
   assign remaining_dec = remaining_ff - 9'd1;
   assign too_large     = 17'(req.word_count) > cfb_pkg::MAX_WORDS_LIMIT;

   always_comb begin
      frame_open_in = frame_open_ff;
      remaining_in  = remaining_ff;
      sum_in        = sum_ff;
      job.kind      = cfb_pkg::JOB_ERROR;
      job.word      = req.command;
      job.count     = req.word_count;
      job.address   = req.address;
      job.checksum  = seed;
      job.close     = 1'b0;
      if (req.operation == cfb_pkg::OP_START) begin
         if (!(frame_open_ff || too_large)) begin
            job.kind  = cfb_pkg::JOB_HEADER;
            job.close = (req.word_count == 9'd0);
            if (accept) begin
               frame_open_in = (req.word_count != 9'd0);
               remaining_in  = req.word_count;
               sum_in        = (req.word_count == 9'd0) ? 16'd0 : seed;
            end
         end
      end else begin
         job.word     = req.data_word;
         job.checksum = data_sum;
         if (frame_open_ff && (remaining_ff != 9'd0)) begin
            job.kind  = cfb_pkg::JOB_DATA;
            job.close = (remaining_dec == 9'd0);
            if (accept) begin
               if (remaining_dec == 9'd0) begin
                  frame_open_in = 1'b0;
                  remaining_in  = 9'd0;
                  sum_in        = 16'd0;
               end else begin
                  remaining_in = remaining_dec;
                  sum_in       = data_sum;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff <= 1'b0;
         remaining_ff  <= 9'd0;
         sum_ff        <= 16'd0;
      end else begin
         frame_open_ff <= frame_open_in;
         remaining_ff  <= remaining_in;
         sum_ff        <= sum_in;
      end
   end

endmodule

`default_nettype wire

### hdl/cfb_queue.sv
// short job queue between the front end and the byte serializer
// depends on cfb_pkg
`timescale 1ns / 1ps
`default_nettype none

module cfb_queue #(
   parameter int unsigned DEPTH = cfb_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire cfb_pkg::job_type wr_job,
   output logic                  full,
   input  wire logic             rd_en,
   output cfb_pkg::job_type      rd_job,
   output logic                  not_empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   cfb_pkg::job_type mem_ff [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign rd_job    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_job;
      end
   end

endmodule

`default_nettype wire

### hdl/cfb_back.sv
// back end: expands queued jobs into frame bytes, one per cycle while its output register is empty or popped
// depends on cfb_pkg
`timescale 1ns / 1ps
`default_nettype none

module cfb_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             job_valid,
   input  wire cfb_pkg::job_type job,
   output logic                  job_done,
   output logic                  empty,
   input  wire logic             pop,
   output cfb_pkg::rsp_type      rsp
);

   logic [cfb_pkg::BYTE_IDX_W-1:0] idx_ff, idx_in;
   logic [cfb_pkg::BYTE_IDX_W-1:0] last_idx;
   logic                           out_valid_ff, out_valid_in;
   cfb_pkg::rsp_type               out_ff, out_in;
   logic                           emit;
   logic [7:0]                     byte_sel;
   logic                           is_last;

   assign emit     = job_valid && (!out_valid_ff || pop);
   assign is_last  = (idx_ff == last_idx);
   assign job_done = emit && is_last;
   assign empty    = !out_valid_ff;
   assign rsp      = out_ff;

   always_comb begin
      last_idx = '0;
      byte_sel = 8'd0;
      unique case (job.kind)
         cfb_pkg::JOB_HEADER: begin
            last_idx = job.close ? 4'd9 : 4'd7;
            unique case (idx_ff)
               4'd0:    byte_sel = cfb_pkg::HEAD_HI;
               4'd1:    byte_sel = cfb_pkg::HEAD_LO;
               4'd2:    byte_sel = job.word[15:8];
               4'd3:    byte_sel = job.word[7:0];
               4'd4:    byte_sel = {7'd0, job.count[8]};
               4'd5:    byte_sel = job.count[7:0];
               4'd6:    byte_sel = job.address[15:8];
               4'd7:    byte_sel = job.address[7:0];
               4'd8:    byte_sel = job.checksum[15:8];
               4'd9:    byte_sel = job.checksum[7:0];
               default: byte_sel = 8'd0;
            endcase
         end
         cfb_pkg::JOB_DATA: begin
            last_idx = job.close ? 4'd3 : 4'd1;
            unique case (idx_ff)
               4'd0:    byte_sel = job.word[15:8];
               4'd1:    byte_sel = job.word[7:0];
               4'd2:    byte_sel = job.checksum[15:8];
               4'd3:    byte_sel = job.checksum[7:0];
               default: byte_sel = 8'd0;
            endcase
         end
         default: begin
            last_idx = '0;
            byte_sel = 8'd0;
         end
      endcase
   end

   always_comb begin
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end
      if (emit) begin
         out_valid_in     = 1'b1;
         out_in.frame_byte = byte_sel;
         out_in.last_byte  = job.close && is_last && (job.kind != cfb_pkg::JOB_ERROR);
         out_in.error      = (job.kind == cfb_pkg::JOB_ERROR);
         idx_in            = is_last ? '0 : idx_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule

`default_nettype wire

### hdl/checksummed_frame_builder_top.sv
// Checksummed frame builder. A start transaction opens a frame and yields the header bytes
// 0x5A 0xA5, command, word count and address (high byte first); each data transaction yields
// its word; the 16-bit additive checksum closes the frame, its low byte flagged last. A
// transaction out of sequence, or a start whose count exceeds the limit, yields one error
// result. The front end takes one transaction per cycle while its job queue has room; the
// serializer sends one byte per cycle while its output is empty or popped: 8 bytes for a
// start (10 when the count is zero), 2 for a data word (4 for the final word) and one for an
// error. A job is queued, and its bytes are registered before reaching the result ports.
// depends on cfb_pkg, cfb_front, cfb_queue, cfb_back
`timescale 1ns / 1ps
`default_nettype none

module checksummed_frame_builder_top #(
   parameter int unsigned QUEUE_DEPTH = cfb_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire cfb_pkg::req_type req_item,
   output logic                  empty,
   input  wire logic             pop,
   output cfb_pkg::rsp_type      rsp_item
);

   logic             accept;
   cfb_pkg::job_type front_job;
   cfb_pkg::job_type head_job;
   logic             head_valid;
   logic             head_done;

   assign accept = push && !full;

   cfb_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_item),
      .job    (front_job)
   );

   cfb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (accept),
      .wr_job    (front_job),
      .full      (full),
      .rd_en     (head_done),
      .rd_job    (head_job),
      .not_empty (head_valid)
   );

   cfb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (head_valid),
      .job       (head_job),
      .job_done  (head_done),
      .empty     (empty),
      .pop       (pop),
      .rsp       (rsp_item)
   );

endmodule

`default_nettype wire
